>>> sv/assert_macros.svh
// Assertion macros used by the row accumulator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SRSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SRSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/srsm_pkg.sv
// Shared types, constants and command structs of the sparse row accumulator.
package srsm_pkg;

   localparam int ROW_CAPACITY_DEF = 64;
   localparam int COLUMN_BITS_DEF  = 16;

   typedef struct packed {
      logic [15:0]        column;
      logic signed [31:0] product_value;
      logic               has_entry;
      logic               row_end;
   } req_item_type;

   typedef struct packed {
      logic [15:0]        merged_column;
      logic signed [31:0] merged_sum;
      logic               last_of_row;
      logic               row_empty;
      logic               overflowed;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_SHIFT_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_ITEM_DONE,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_EMIT_FIN
   } state_type;

   typedef struct packed {
      logic accept;
      logic idx_clr;
      logic idx_inc;
      logic idx_dec;
      logic idx_to_count;
      logic pos_save;
      logic rd_en;
      logic rd_shift;
      logic wr_merge;
      logic wr_shift;
      logic wr_new;
      logic count_inc;
      logic ovf_set;
      logic emit_push;
      logic emit_final;
   } cmd_type;

   typedef struct packed {
      logic has_entry;
      logic row_end;
      logic idx_lt_count;
      logic idx_gt_pos;
      logic rd_lt;
      logic rd_eq;
      logic full;
      logic skip;
      logic pend_valid;
      logic out_full;
   } status_type;

endpackage

>>> sv/srsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/srsm_ctrl.sv
// Controller state machine: insertion search, shift, and row emission sequencing.
module srsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  srsm_pkg::status_type sts,
   output srsm_pkg::cmd_type    cmd
);
   import srsm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (sts.has_entry) state_in = ST_SEARCH_RD;
            else if (sts.row_end) state_in = ST_EMIT_RD;
            else state_in = ST_IDLE;
         end
         ST_SEARCH_RD: state_in = sts.idx_lt_count ? ST_SEARCH_CMP : ST_SHIFT_CHK;
         ST_SEARCH_CMP: begin
            if (sts.rd_lt) state_in = ST_SEARCH_RD;
            else if (sts.rd_eq) state_in = ST_ITEM_DONE;
            else state_in = ST_SHIFT_CHK;
         end
         ST_SHIFT_CHK: state_in = sts.full ? ST_ITEM_DONE : ST_SHIFT_RD;
         ST_SHIFT_RD: state_in = sts.idx_gt_pos ? ST_SHIFT_WR : ST_ITEM_DONE;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_ITEM_DONE: state_in = sts.row_end ? ST_EMIT_RD : ST_IDLE;
         ST_EMIT_RD: state_in = sts.idx_lt_count ? ST_EMIT_CHK : ST_EMIT_FIN;
         ST_EMIT_CHK: begin
            if (sts.skip || !(sts.pend_valid && sts.out_full)) state_in = ST_EMIT_RD;
         end
         ST_EMIT_FIN: if (!sts.out_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
            cmd.idx_clr = 1'b1;
         end
         ST_DISPATCH: ;
         ST_SEARCH_RD: begin
            cmd.rd_en = sts.idx_lt_count;
            cmd.pos_save = !sts.idx_lt_count;
         end
         ST_SEARCH_CMP: begin
            cmd.idx_inc = sts.rd_lt;
            cmd.wr_merge = sts.rd_eq;
            cmd.pos_save = !sts.rd_lt && !sts.rd_eq;
         end
         ST_SHIFT_CHK: begin
            cmd.ovf_set = sts.full;
            cmd.idx_to_count = !sts.full;
         end
         ST_SHIFT_RD: begin
            cmd.rd_en = sts.idx_gt_pos;
            cmd.rd_shift = 1'b1;
            cmd.wr_new = !sts.idx_gt_pos;
            cmd.count_inc = !sts.idx_gt_pos;
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec = 1'b1;
         end
         ST_ITEM_DONE: cmd.idx_clr = 1'b1;
         ST_EMIT_RD: cmd.rd_en = sts.idx_lt_count;
         ST_EMIT_CHK: begin
            if (sts.skip) begin
               cmd.idx_inc = 1'b1;
            end else if (!(sts.pend_valid && sts.out_full)) begin
               cmd.emit_push = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EMIT_FIN: cmd.emit_final = !sts.out_full;
         default: ;
      endcase
   end
endmodule

>>> sv/srsm_datapath.sv
// Datapath: item registers, index counters, entry store, merge adder and result register.
module srsm_datapath #(
   parameter int ROW_CAPACITY = srsm_pkg::ROW_CAPACITY_DEF,
   parameter int COLUMN_BITS  = srsm_pkg::COLUMN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srsm_pkg::req_item_type req_item,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  srsm_pkg::cmd_type      cmd,
   output srsm_pkg::status_type   sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output srsm_pkg::rsp_item_type rsp_item
);
   import srsm_pkg::*;
`include "assert_macros.svh"

   localparam int CW = $clog2(ROW_CAPACITY + 1);
   localparam int AW = $clog2(ROW_CAPACITY);
   localparam int EW = COLUMN_BITS + 32;

   logic [COLUMN_BITS-1:0] col_ff;
   logic signed [31:0]     val_ff;
   logic                   has_ff, end_ff;
   logic [CW-1:0]          idx_ff, idx_in, pos_ff, count_ff, count_in;
   logic                   ovf_ff, ovf_in, drop_ff;
   logic [EW-1:0]          pend_ff;
   logic                   pend_valid_ff, pend_valid_in;
   rsp_item_type           out_ff, out_in;
   logic                   out_full_ff, out_full_in;

   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [EW-1:0]          wr_data, rd_data;
   logic [COLUMN_BITS-1:0] rd_col, pend_col;
   logic signed [31:0]     rd_val, sum;
   logic signed [32:0]     wide_sum;

   assign rd_col   = rd_data[EW-1:32];
   assign rd_val   = rd_data[31:0];
   assign pend_col = pend_ff[EW-1:32];

   // Saturating merge of the arriving value into the stored one.
   assign wide_sum = {rd_val[31], rd_val} + {val_ff[31], val_ff};
   always_comb begin
      if (wide_sum[32] != wide_sum[31]) begin
         sum = wide_sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         sum = wide_sum[31:0];
      end
   end

   assign rd_en   = cmd.rd_en;
   assign rd_addr = cmd.rd_shift ? AW'(idx_ff - 1'b1) : AW'(idx_ff);
   assign wr_en   = cmd.wr_merge || cmd.wr_shift || cmd.wr_new;
   assign wr_addr = AW'(idx_ff);
   always_comb begin
      if (cmd.wr_merge) wr_data = {rd_col, sum};
      else if (cmd.wr_shift) wr_data = rd_data;
      else wr_data = {col_ff, val_ff};
   end

   srsm_ram #(.WIDTH(EW), .DEPTH(ROW_CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
      else if (cmd.idx_dec) idx_in = idx_ff - 1'b1;
      else if (cmd.idx_to_count) idx_in = count_ff;

      count_in = count_ff;
      ovf_in = ovf_ff;
      if (cmd.count_inc) count_in = count_ff + 1'b1;
      if (cmd.ovf_set) ovf_in = 1'b1;
      if (cmd.emit_final) begin
         count_in = '0;
         ovf_in = 1'b0;
      end

      out_full_in = out_full_ff && rsp_stall;
      out_in = out_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.emit_push) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            out_full_in = 1'b1;
            out_in.merged_column = 16'(pend_col);
            out_in.merged_sum = pend_ff[31:0];
            out_in.last_of_row = 1'b0;
            out_in.row_empty = 1'b0;
            out_in.overflowed = ovf_ff;
         end
      end
      if (cmd.emit_final) begin
         pend_valid_in = 1'b0;
         out_full_in = 1'b1;
         out_in.merged_column = pend_valid_ff ? 16'(pend_col) : 16'd0;
         out_in.merged_sum = pend_valid_ff ? pend_ff[31:0] : 32'sd0;
         out_in.last_of_row = 1'b1;
         out_in.row_empty = !pend_valid_ff;
         out_in.overflowed = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         drop_ff <= 1'b1;
         pend_valid_ff <= 1'b0;
         out_full_ff <= 1'b0;
         has_ff <= 1'b0;
         end_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_full_ff <= out_full_in;
         if (csr_wr_en) drop_ff <= csr_wr_data;
         if (cmd.accept) begin
            has_ff <= req_item.has_entry;
            end_ff <= req_item.row_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_ff <= COLUMN_BITS'(req_item.column);
         val_ff <= req_item.product_value;
      end
      if (cmd.pos_save) pos_ff <= idx_ff;
      if (cmd.emit_push) pend_ff <= rd_data;
      out_ff <= out_in;
   end

   always_comb begin
      sts.has_entry    = has_ff;
      sts.row_end      = end_ff;
      sts.idx_lt_count = idx_ff < count_ff;
      sts.idx_gt_pos   = idx_ff > pos_ff;
      sts.rd_lt        = rd_col < col_ff;
      sts.rd_eq        = rd_col == col_ff;
      sts.full         = count_ff == CW'(ROW_CAPACITY);
      sts.skip         = drop_ff && (rd_val == 32'sd0);
      sts.pend_valid   = pend_valid_ff;
      sts.out_full     = out_full_ff;
   end

   assign rsp_valid = out_full_ff;
   assign rsp_item  = out_ff;

   `SRSM_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(ROW_CAPACITY))
   `SRSM_ASSERT_SAME(a_ovf_only_full, clock, reset, ovf_ff, count_ff == CW'(ROW_CAPACITY))
   `SRSM_ASSERT_NEXT(a_final_clears, clock, reset, cmd.emit_final,
                     count_ff == '0 && !ovf_ff && out_full_ff && out_ff.last_of_row)
endmodule

>>> sv/sparse_row_sort_merge.sv
// Sparse row accumulator: each accepted item that carries an entry is inserted into a
// column-sorted store (merged by saturating add when the column is already held, dropped
// with the overflow flag set when the store is full) by a walk over the store RAM that
// reads one entry at a time; no new item is taken until the last one is done. A row-end
// item then reads the store out entry by entry, more slowly while results are stalled.
// No clearing pass is needed after reset.
module sparse_row_sort_merge #(
   parameter int ROW_CAPACITY = srsm_pkg::ROW_CAPACITY_DEF,
   parameter int COLUMN_BITS  = srsm_pkg::COLUMN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  srsm_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output srsm_pkg::rsp_item_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);
   import srsm_pkg::*;

   cmd_type    cmd;
   status_type sts;

   srsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srsm_datapath #(.ROW_CAPACITY(ROW_CAPACITY), .COLUMN_BITS(COLUMN_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );
endmodule

>>> tb/sparse_row_sort_merge_tb.sv
// Testbench for the sparse row accumulator: directed table, random rows, self-checking predictor.
module sparse_row_sort_merge_tb;
   import srsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 64;
   localparam int CYCLE_LIMIT = 900000;
   localparam logic [31:0] SUM_MAX = 32'h7fffffff;
   localparam logic [31:0] SUM_MIN = 32'h80000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   sparse_row_sort_merge dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Predictor state: sorted columns and sums of the open row.
   logic [15:0] row_cols[CAPACITY];
   logic signed [31:0] row_sums[CAPACITY];
   int row_count = 0;
   logic row_ovf = 1'b0;
   logic drop_zero = 1'b1;
   rsp_item_type expected_q[$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   // Directed table: item plus typed expectation where it is obvious.
   typedef struct {
      req_item_type item;
      logic has_typed;
      rsp_item_type typed;
   } table_row_type;
   table_row_type directed[$];

   function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s > 33'sh07fffffff) return SUM_MAX;
      if (s < -33'sh080000000) return SUM_MIN;
      return s[31:0];
   endfunction

   // Inserts one item into the row model and queues the row's results at its end.
   task automatic accumulate(input req_item_type it);
      int pos;
      int i;
      int n;
      rsp_item_type r;
      pos = 0;
      if (it.has_entry) begin
         while (pos < row_count && row_cols[pos] < it.column) pos++;
         if (pos < row_count && row_cols[pos] == it.column) begin
            row_sums[pos] = sat_sum(row_sums[pos], it.product_value);
         end else if (row_count >= CAPACITY) begin
            row_ovf = 1'b1;
         end else begin
            for (i = row_count; i > pos; i--) begin
               row_cols[i] = row_cols[i-1];
               row_sums[i] = row_sums[i-1];
            end
            row_cols[pos] = it.column;
            row_sums[pos] = it.product_value;
            row_count++;
         end
      end
      if (!it.row_end) return;
      n = 0;
      for (i = 0; i < row_count; i++) begin
         if (drop_zero && row_sums[i] == 0) continue;
         r = '0;
         r.merged_column = row_cols[i];
         r.merged_sum = row_sums[i];
         r.overflowed = row_ovf;
         expected_q.push_back(r);
         n++;
      end
      if (n == 0) begin
         r = '0;
         r.last_of_row = 1'b1;
         r.row_empty = 1'b1;
         r.overflowed = row_ovf;
         expected_q.push_back(r);
      end else begin
         expected_q[$].last_of_row = 1'b1;
      end
      row_count = 0;
      row_ovf = 1'b0;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   // Result checker at the rising edge.
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report("unexpected item", 32'(rsp_item.merged_column), 32'd0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_item.merged_column !== e.merged_column)
               report("merged_column", 32'(rsp_item.merged_column), 32'(e.merged_column));
            if (rsp_item.merged_sum !== e.merged_sum)
               report("merged_sum", rsp_item.merged_sum, e.merged_sum);
            if (rsp_item.last_of_row !== e.last_of_row)
               report("last_of_row", 32'(rsp_item.last_of_row), 32'(e.last_of_row));
            if (rsp_item.row_empty !== e.row_empty)
               report("row_empty", 32'(rsp_item.row_empty), 32'(e.row_empty));
            if (rsp_item.overflowed !== e.overflowed)
               report("overflowed", 32'(rsp_item.overflowed), 32'(e.overflowed));
         end
      end
   end

   // Receiver stall, with an optional long hold-off counted here.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offers one item until it is accepted; the predictor sees it at acceptance.
   // The accepted item stays on the port until the next falling edge, where the
   // next call or the drain task takes the input over.
   task automatic send(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate(it);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (3 * CAPACITY + 20) @(negedge clock);
   endtask

   task automatic write_drop_zero(input logic v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      drop_zero = v;
   endtask

   function automatic req_item_type mk(logic [15:0] c, logic [31:0] v, logic h, logic e);
      req_item_type it;
      it.column = c;
      it.product_value = v;
      it.has_entry = h;
      it.row_end = e;
      return it;
   endfunction

   function automatic rsp_item_type rs(logic [15:0] c, logic [31:0] v, logic l, logic em);
      rsp_item_type r;
      r = '0;
      r.merged_column = c;
      r.merged_sum = v;
      r.last_of_row = l;
      r.row_empty = em;
      return r;
   endfunction

   task automatic add_row(input req_item_type it, input logic typed, input rsp_item_type r);
      table_row_type t;
      t.item = it;
      t.has_typed = typed;
      t.typed = r;
      directed.push_back(t);
   endtask

   // A random row: mostly narrow columns so merges happen; sometimes many distinct ones.
   task automatic random_row(input int len, input int col_span);
      int i;
      logic [31:0] v;
      for (i = 0; i < len; i++) begin
         case ($urandom_range(5))
            0: v = SUM_MAX - $urandom_range(3);
            1: v = SUM_MIN + $urandom_range(3);
            2: v = 32'($signed($urandom_range(6)) - 3);
            default: v = $urandom;
         endcase
         if ($urandom_range(9) == 0)
            send(mk(16'($urandom), $urandom, 1'b0, 1'b0));
         send(mk(16'($urandom_range(col_span)), v, $urandom_range(7) != 0, i == len - 1));
      end
   endtask

   initial begin
      req_item_type it;
      rsp_item_type got_before;
      int i;
      int phase;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table; drop of zero sums is on after reset.
      add_row(mk(16'd0, 32'd0, 1'b0, 1'b1), 1'b1, rs(16'd0, 32'd0, 1'b1, 1'b1));
      add_row(mk(16'hffff, SUM_MAX, 1'b1, 1'b1), 1'b1, rs(16'hffff, SUM_MAX, 1'b1, 1'b0));
      add_row(mk(16'd0, SUM_MIN, 1'b1, 1'b1), 1'b1, rs(16'd0, SUM_MIN, 1'b1, 1'b0));
      add_row(mk(16'd7, SUM_MAX, 1'b1, 1'b0), 1'b0, '0);
      add_row(mk(16'd7, 32'd5, 1'b1, 1'b1), 1'b1, rs(16'd7, SUM_MAX, 1'b1, 1'b0));
      add_row(mk(16'd9, SUM_MIN, 1'b1, 1'b0), 1'b0, '0);
      add_row(mk(16'd9, 32'hffffffff, 1'b1, 1'b1), 1'b1, rs(16'd9, SUM_MIN, 1'b1, 1'b0));
      add_row(mk(16'd3, 32'd4, 1'b1, 1'b0), 1'b0, '0);
      add_row(mk(16'd3, -32'sd4, 1'b1, 1'b1), 1'b1, rs(16'd0, 32'd0, 1'b1, 1'b1));
      add_row(mk(16'h5555, 32'hdead, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk(16'd20, 32'd1, 1'b1, 1'b0), 1'b0, '0);
      add_row(mk(16'd2, 32'd2, 1'b1, 1'b0), 1'b0, '0);
      add_row(mk(16'd11, 32'd3, 1'b1, 1'b0), 1'b0, '0);
      add_row(mk(16'd2, 32'd5, 1'b0, 1'b1), 1'b0, '0);
      for (i = 0; i < directed.size(); i++) begin
         if (directed[i].has_typed) begin
            it = directed[i].item;
            send(it);
            got_before = expected_q[$];
            if (got_before !== directed[i].typed)
               report("table row", 32'(i), 32'd0);
         end else begin
            send(directed[i].item);
         end
      end
      wait_drained();

      // Store full: 66 distinct columns, then a merge into a held one.
      write_drop_zero(1'b0);
      for (i = 0; i < CAPACITY + 2; i++)
         send(mk(16'(1000 - i), 32'(i), 1'b1, 1'b0));
      send(mk(16'd1000, 32'd1, 1'b1, 1'b1));
      send(mk(16'd1, 32'd0, 1'b1, 1'b1));
      wait_drained();

      // Random phases across idling mixes and register settings.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         write_drop_zero(phase[0]);
         if (phase == 2) hold_cycles = 400;
         for (i = 0; i < 8; i++) begin
            if ($urandom_range(7) == 0) random_row($urandom_range(1, 3), 65535);
            else random_row($urandom_range(1, 5), $urandom_range(3, 12));
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
